// ===== sv/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and codes for the sorted timer task queue.
// ----------------------------------------------------------------------------
package stq_pkg;

	typedef enum logic [1:0] {
		FUNC_POST = 2'd0,
		FUNC_TICK = 2'd1,
		FUNC_SET  = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		KIND_POSTED  = 3'd0,
		KIND_FULL    = 3'd1,
		KIND_RT_FIRE = 3'd2,
		KIND_DUE     = 3'd3,
		KIND_NONE    = 3'd4
	} kind_t;

	// control states of the top level
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POST,
		ST_SET,
		ST_TICK,
		ST_POP,
		ST_NONE
	} st_t;

	// command into the row of cells
	typedef struct packed {
		logic ins;   // insert the carried entry at its sorted place
		logic pop;   // shift the row down by one
	} cell_cmd_t;

	localparam int unsigned US_PER_MS = 1000;

endpackage

// ===== sv/stq_cell.sv =====
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted row: holds a deadline and tag, takes from neighbours.
// ----------------------------------------------------------------------------
module stq_cell import stq_pkg::*; #(
	parameter int TW = 48,
	parameter int GW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_cmd_t     cmd,
	input  logic [TW-1:0] new_dl,
	input  logic [GW-1:0] new_tag,
	input  logic          prev_v,
	input  logic          prev_gt,   // previous cell is after the new entry
	input  logic [TW-1:0] prev_dl,
	input  logic [GW-1:0] prev_tag,
	input  logic          next_v,
	input  logic [TW-1:0] next_dl,
	input  logic [GW-1:0] next_tag,
	output logic          v,
	output logic          gt,
	output logic [TW-1:0] dl,
	output logic [GW-1:0] tag
);
	logic v_q;
	logic [TW-1:0] dl_q;
	logic [GW-1:0] tag_q;

	assign v   = v_q;
	assign dl  = dl_q;
	assign tag = tag_q;
	// equal deadlines stay ahead of the new entry
	assign gt  = !v_q || (dl_q > new_dl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (cmd.pop) begin
			v_q <= next_v;
		end else if (cmd.ins && gt) begin
			v_q <= prev_gt ? prev_v : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			dl_q  <= next_dl;
			tag_q <= next_tag;
		end else if (cmd.ins && gt) begin
			dl_q  <= prev_gt ? prev_dl : new_dl;
			tag_q <= prev_gt ? prev_tag : new_tag;
		end
	end
endmodule

// ===== sv/sorted_timer_task_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_task_queue
// Deadline-sorted timer queue built as a shifting row of cells.
// ----------------------------------------------------------------------------
// channel | signals                                        | handshake
// in      | func task_tag delay_us deadline_ms deadline_valid | start & !busy
// out     | kind due_tag next_wakeup_us more_pending last  | strobe, 1 cycle
// Post and set run a compute step, then a result step. Tick runs a tick step
// (timer fire), then a pop step per due entry, up to MAX_DUE_PER_TICK, or a
// none step when nothing is due and no timer fired; each pop shifts the row.
// Insertion is a single parallel shift of the cell row at the cell compares.
// Reset clears all cells' valid bits at once; no clearing pass.
// Results cannot be stalled; busy stays high until the final result.
// ----------------------------------------------------------------------------
module sorted_timer_task_queue import stq_pkg::*; #(
	parameter int QUEUE_DEPTH      = 256,
	parameter int MAX_DUE_PER_TICK = 16,
	parameter int TAG_WIDTH        = 16,
	parameter int TIME_WIDTH       = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           func,
	input  logic [TAG_WIDTH-1:0] task_tag,
	input  logic [31:0]          delay_us,
	input  logic [38:0]          deadline_ms,
	input  logic                 deadline_valid,
	output logic                 strobe,
	output logic [2:0]           kind,
	output logic [15:0]          due_tag,
	output logic [47:0]          next_wakeup_us,
	output logic                 more_pending,
	output logic                 last
);
	localparam int TW = TIME_WIDTH;
	localparam int N  = QUEUE_DEPTH;
	localparam int CW = $clog2(MAX_DUE_PER_TICK + 1);
	localparam logic [TW-1:0] TMAX = {TW{1'b1}};

	st_t st_q, st_d;

	logic [TW-1:0] now_q, rt_dl_q, new_dl_q;
	logic          rt_arm_q;
	logic [TAG_WIDTH-1:0] new_tag_q;
	logic [49:0]   ms_prod_q;
	logic          ms_arm_q;
	logic [CW-1:0] pops_q;
	logic          fired_q;

	logic [N:0]    cv, cgt;
	logic [TW-1:0] cdl  [0:N];
	logic [TAG_WIDTH-1:0] ctag [0:N];
	cell_cmd_t     cmd;

	// sentinel beyond the row end
	assign cv[N]   = 1'b0;
	assign cdl[N]  = '0;
	assign ctag[N] = '0;

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			stq_cell #(.TW(TW), .GW(TAG_WIDTH)) u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd),
				.new_dl(new_dl_q), .new_tag(new_tag_q),
				.prev_v  (g == 0 ? 1'b0 : cv[g == 0 ? 0 : g-1]),
				.prev_gt (g == 0 ? 1'b0 : cgt[g == 0 ? 0 : g-1]),
				.prev_dl (cdl[g == 0 ? 0 : g-1]),
				.prev_tag(ctag[g == 0 ? 0 : g-1]),
				.next_v(cv[g+1]), .next_dl(cdl[g+1]), .next_tag(ctag[g+1]),
				.v(cv[g]), .gt(cgt[g]), .dl(cdl[g]), .tag(ctag[g])
			);
		end
	endgenerate
	assign cgt[N] = 1'b1;

	logic head_due, full;
	assign head_due = cv[0] && (cdl[0] <= now_q);
	assign full     = cv[N-1];

	// wakeup after the event: values after this cycle's update
	logic          arm_n, qv_n;
	logic [TW-1:0] rtd_n, hd_n, wk;
	always_comb begin
		arm_n = rt_arm_q; rtd_n = rt_dl_q;
		qv_n = cv[0]; hd_n = cdl[0];
		case (st_q)
			ST_SET: begin
				arm_n = ms_arm_q;
				rtd_n = !ms_arm_q ? TMAX :
					({14'd0, ms_prod_q} > 64'(TMAX) ? TMAX : TW'(ms_prod_q));
			end
			ST_TICK: if (rt_arm_q && now_q >= rt_dl_q) begin
				arm_n = 1'b0; rtd_n = TMAX;
			end
			ST_POP: begin qv_n = cv[1]; hd_n = cdl[1]; end
			ST_POST: if (!full) begin
				qv_n = 1'b1;
				hd_n = cgt[0] ? new_dl_q : cdl[0];
			end
			default: ;
		endcase
		wk = TMAX;
		if (arm_n && rtd_n < wk) wk = rtd_n;
		if (qv_n && hd_n < wk) wk = hd_n;
	end

	logic rt_fire;
	assign rt_fire = rt_arm_q && now_q >= rt_dl_q;

	always_comb begin
		st_d = st_q; cmd = '0; strobe = 1'b0; kind = KIND_NONE;
		due_tag = '0; last = 1'b0;
		busy = (st_q != ST_IDLE);
		case (st_q)
			ST_IDLE: if (start) begin
				case (func_t'(func))
					FUNC_POST: st_d = ST_POST;
					FUNC_TICK: st_d = ST_TICK;
					FUNC_SET:  st_d = ST_SET;
					default:   st_d = ST_IDLE;
				endcase
			end
			ST_POST: begin
				strobe = 1'b1; last = 1'b1;
				kind = full ? KIND_FULL : KIND_POSTED;
				cmd.ins = !full;
				st_d = ST_IDLE;
			end
			ST_SET: begin
				strobe = 1'b1; last = 1'b1; st_d = ST_IDLE;
			end
			ST_TICK: begin
				if (rt_fire) begin
					strobe = 1'b1; kind = KIND_RT_FIRE;
					last = !head_due;
				end
				st_d = head_due ? ST_POP : (rt_fire ? ST_IDLE : ST_NONE);
			end
			ST_POP: begin
				strobe = 1'b1; kind = KIND_DUE; cmd.pop = 1'b1;
				due_tag = 16'(ctag[0]);
				last = (pops_q == CW'(MAX_DUE_PER_TICK - 1)) ||
					!(cv[1] && cdl[1] <= now_q);
				st_d = last ? ST_IDLE : ST_POP;
			end
			ST_NONE: begin
				strobe = 1'b1; last = 1'b1; st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign next_wakeup_us = 48'(wk);
	assign more_pending   = arm_n || qv_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; now_q <= '0; rt_dl_q <= TMAX; rt_arm_q <= 1'b0;
			pops_q <= '0; fired_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_IDLE && start && func_t'(func) == FUNC_TICK && now_q != TMAX)
				now_q <= now_q + 1'b1;
			if (st_q == ST_SET || st_q == ST_TICK) begin
				rt_arm_q <= arm_n; rt_dl_q <= rtd_n;
			end
			fired_q <= (st_q == ST_TICK) ? rt_fire : fired_q;
			pops_q <= (st_q == ST_POP) ? pops_q + 1'b1 : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			new_tag_q <= task_tag;
			new_dl_q  <= ({32'd0, delay_us} > 64'(TMAX - now_q)) ? TMAX
				: now_q + TW'(delay_us);
			ms_prod_q <= {11'd0, deadline_ms} * 50'(US_PER_MS);
			ms_arm_q  <= deadline_valid;
		end
	end

	// result strobes only while busy
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("strobe while idle");
	// a final result always returns to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !busy) else $error("busy after last");
	// popped entries are due
	a_pop_due: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_POP) |-> head_due) else $error("pop of entry not due");
	// the timer fire is reported at most once per tick
	a_fire_once: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_POP) |-> kind != KIND_RT_FIRE || fired_q)
		else $error("fire in pop");
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted timer task queue: requests from a
// queue driven under random idling, results checked against a local model.
// ----------------------------------------------------------------------------
module tb;
	import stq_pkg::*;

	localparam logic [47:0] T_MAX = '1;
	localparam int DEPTH    = 256;
	localparam int MAX_POPS = 16;
	localparam int WD_LIMIT = 2000;

	typedef struct {
		logic [1:0]  func;
		logic [15:0] tag;
		logic [31:0] delay;
		logic [38:0] dms;
		logic        dvalid;
	} req_t;

	typedef struct {
		logic [2:0]  kind;
		logic [15:0] tag;
		logic [47:0] wake;
		logic        more;
		logic        last;
	} res_t;

	typedef struct {
		logic [47:0] dl;
		logic [15:0] tag;
	} timer_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [1:0] func = 0;
	logic [15:0] task_tag = 0;
	logic [31:0] delay_us = 0;
	logic [38:0] deadline_ms = 0;
	logic deadline_valid = 0;
	logic busy, strobe, more_pending, last;
	logic [2:0] kind;
	logic [15:0] due_tag;
	logic [47:0] next_wakeup_us;

	req_t   pending[$];
	res_t   expected_res[$];
	timer_t timers[$];
	req_t   cur;
	logic [47:0] now_us = 0;
	logic [47:0] rt_deadline = T_MAX;
	logic        rt_armed = 0;
	int errors = 0;
	int n_sent = 0;
	int n_total = 0;
	int quiet = 0;
	bit running = 0;

	sorted_timer_task_queue dut (.*);

	initial forever #5 clk = ~clk;

	function automatic logic [47:0] earliest();
		logic [47:0] w;
		w = T_MAX;
		if (rt_armed && rt_deadline < w) w = rt_deadline;
		if (timers.size() > 0 && timers[0].dl < w) w = timers[0].dl;
		return w;
	endfunction

	task automatic push_res(input kind_t k, input logic [15:0] t);
		res_t r;
		r.kind = k;
		r.tag  = t;
		r.wake = earliest();
		r.more = rt_armed || timers.size() > 0;
		r.last = 0;
		expected_res.push_back(r);
	endtask

	task automatic predict(input req_t q);
		int n0, i, popped;
		logic [48:0] sum;
		logic [63:0] us;
		timer_t e;
		n0 = expected_res.size();
		case (q.func)
			FUNC_POST: begin
				if (timers.size() >= DEPTH) begin
					push_res(KIND_FULL, 0);
				end else begin
					sum = {1'b0, now_us} + q.delay;
					e.dl = sum[48] ? T_MAX : sum[47:0];
					e.tag = q.tag;
					i = 0;
					while (i < timers.size() && timers[i].dl <= e.dl) i++;
					timers.insert(i, e);
					push_res(KIND_POSTED, 0);
				end
			end
			FUNC_TICK: begin
				if (now_us < T_MAX) now_us++;
				if (rt_armed && now_us >= rt_deadline) begin
					rt_armed = 0;
					rt_deadline = T_MAX;
					push_res(KIND_RT_FIRE, 0);
				end
				popped = 0;
				while (popped < MAX_POPS && timers.size() > 0 && timers[0].dl <= now_us) begin
					e = timers.pop_front();
					popped++;
					push_res(KIND_DUE, e.tag);
				end
				if (expected_res.size() == n0) push_res(KIND_NONE, 0);
			end
			FUNC_SET: begin
				if (q.dvalid) begin
					us = 64'(q.dms) * US_PER_MS;
					rt_deadline = (us > 64'(T_MAX)) ? T_MAX : us[47:0];
					rt_armed = 1;
				end else begin
					rt_deadline = T_MAX;
					rt_armed = 0;
				end
				push_res(KIND_NONE, 0);
			end
			default: ;
		endcase
		if (expected_res.size() > n0) expected_res[expected_res.size()-1].last = 1;
	endtask

	function automatic int idle_pct();
		if (n_sent < n_total / 3) return 24;
		if (n_sent < 2 * n_total / 3) return 56;
		return 0;
	endfunction

	function automatic req_t mk(input logic [1:0] f, input logic [15:0] t,
			input logic [31:0] d, input logic [38:0] ms, input logic v);
		req_t q;
		q.func = f; q.tag = t; q.delay = d; q.dms = ms; q.dvalid = v;
		return q;
	endfunction

	function automatic req_t rnd_req(input int sel);
		req_t q;
		q = mk(2'($urandom), 16'($urandom), {$urandom}, {7'($urandom), $urandom}, 1'($urandom));
		if (sel < 40) begin
			q.func = FUNC_POST;
			if ($urandom_range(9) != 0) q.delay = $urandom_range(8);
		end else if (sel < 80) begin
			q.func = FUNC_TICK;
		end else if (sel < 92) begin
			q.func = FUNC_SET;
			if ($urandom_range(3) != 0) q.dms = 39'($urandom_range(3));
		end else begin
			q.func = FUNC_NONE;
		end
		return q;
	endfunction

	// driver: one assignment per signal per edge
	always @(posedge clk) begin
		if (running) begin
			if (start && !busy) begin
				predict(cur);
				n_sent++;
			end
			if ((!start || !busy) && pending.size() > 0 && $urandom_range(99) >= idle_pct()) begin
				cur = pending.pop_front();
				start <= 1;
				func <= cur.func;
				task_tag <= cur.tag;
				delay_us <= cur.delay;
				deadline_ms <= cur.dms;
				deadline_valid <= cur.dvalid;
			end else if (start && !busy) begin
				start <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t x;
		if (running && strobe) begin
			if (expected_res.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result kind=%0d tag=%h", kind, due_tag);
			end else begin
				x = expected_res.pop_front();
				if (kind !== x.kind || due_tag !== x.tag || next_wakeup_us !== x.wake ||
						more_pending !== x.more || last !== x.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp k=%0d t=%h w=%h m=%b l=%b got k=%0d t=%h w=%h m=%b l=%b",
							x.kind, x.tag, x.wake, x.more, x.last,
							kind, due_tag, next_wakeup_us, more_pending, last);
				end
			end
		end
	end

	// watchdog on cycles with no request or result accepted
	always @(posedge clk) begin
		if (running) begin
			if ((start && !busy) || strobe) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet >= WD_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int i;
		// directed
		pending.push_back(mk(FUNC_SET, 0, 0, '1, 1));          // ms overflow saturates
		pending.push_back(mk(FUNC_SET, 0, 0, 1, 0));           // clear
		pending.push_back(mk(FUNC_TICK, 0, 0, 0, 0));          // nothing due
		pending.push_back(mk(FUNC_POST, 16'hffff, 0, 0, 0));
		pending.push_back(mk(FUNC_POST, 16'h0000, 0, 0, 0));   // equal deadline after
		pending.push_back(mk(FUNC_POST, 16'h1234, '1, 0, 0));  // longest delay
		pending.push_back(mk(FUNC_SET, 0, 0, 0, 1));           // already past
		pending.push_back(mk(FUNC_TICK, 0, 0, 0, 0));          // fires and pops two
		pending.push_back(mk(FUNC_NONE, 16'hffff, '1, '1, 1)); // ignored
		pending.push_back(mk(FUNC_SET, 0, 0, 1, 1));
		pending.push_back(mk(FUNC_POST, 16'h00a5, 3, 0, 0));
		pending.push_back(mk(FUNC_POST, 16'h005a, 2, 0, 0));
		pending.push_back(mk(FUNC_POST, 16'h0f0f, 2, 0, 0));
		for (i = 0; i < 4; i++) pending.push_back(mk(FUNC_TICK, 0, 0, 0, 0));
		pending.push_back(mk(FUNC_POST, 16'h8001, 1000, 0, 0));
		pending.push_back(mk(FUNC_SET, 0, 0, 39'h5555555555, 1));
		pending.push_back(mk(FUNC_SET, 0, 0, 39'h2aaaaaaaaa, 1));
		pending.push_back(mk(FUNC_SET, 0, 0, 0, 0));
		for (i = 0; i < 42; i++) pending.push_back(rnd_req($urandom_range(99)));
		// fill the pool past full, then drain in bounded batches
		for (i = 0; i < 262; i++) begin
			pending.push_back(mk(FUNC_POST, 16'($urandom),
				($urandom_range(19) == 0) ? {$urandom} : $urandom_range(40), 0, 0));
		end
		for (i = 0; i < 45; i++) pending.push_back(rnd_req(40 + $urandom_range(51)));
		n_total = pending.size();

		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		running = 1;
		while (pending.size() > 0 || start) @(posedge clk);
		while (expected_res.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
